// ===== design/sbq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo biquad filter package
// Shared types, register codes and fixed-point helpers for the stereo
// direct form I biquad filter.
// ----------------------------------------------------------------------------
package sbq_pkg;

  localparam int unsigned COEF_W    = 32;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned STATE_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SUM_W     = 67;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh1000_0000;

  localparam logic signed [30:0] OUT_MAX = 31'sd32767;
  localparam logic signed [30:0] OUT_MIN = -31'sd32768;
  localparam logic signed [38:0] STATE_MAX = 39'sh00_7FFF_FFFF;
  localparam logic signed [38:0] STATE_MIN = -39'sh00_8000_0000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       chunk_end_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       chunk_end_out;
  } out_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  // The sum is at Q.36; the output is its integer part, truncated toward zero and saturated to 16 bits.
  function automatic logic signed [SAMPLE_W-1:0] out_sample(
    input logic signed [SUM_W-1:0] sum
  );
    logic signed [30:0] q;
    logic signed [SAMPLE_W-1:0] res;
    q = sum[SUM_W-1:36];
    if (sum[SUM_W-1] && (|sum[35:0])) begin
      q = q + 31'sd1;
    end
    if (q > OUT_MAX) begin
      res = OUT_MAX[SAMPLE_W-1:0];
    end else if (q < OUT_MIN) begin
      res = OUT_MIN[SAMPLE_W-1:0];
    end else begin
      res = q[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // Feedback state is the sum truncated toward zero to Q24.8 and saturated.
  function automatic logic signed [STATE_W-1:0] state_value(
    input logic signed [SUM_W-1:0] sum
  );
    logic signed [38:0] q;
    logic signed [STATE_W-1:0] res;
    q = sum[SUM_W-1:28];
    if (sum[SUM_W-1] && (|sum[27:0])) begin
      q = q + 39'sd1;
    end
    if (q > STATE_MAX) begin
      res = STATE_MAX[STATE_W-1:0];
    end else if (q < STATE_MIN) begin
      res = STATE_MIN[STATE_W-1:0];
    end else begin
      res = q[STATE_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== design/sbq_channel.sv =====
// ----------------------------------------------------------------------------
// Stereo biquad channel
// One direct form I biquad channel: its delay lines and the combinational
// multiply, sum, truncate and saturate path.
// ----------------------------------------------------------------------------
module sbq_channel
  import sbq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  logic                       update,
  input  coef_t                      coef,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  logic signed [SAMPLE_W-1:0] x1_r, x2_r;
  logic signed [STATE_W-1:0]  y1_r, y2_r;

  logic signed [47:0]      prod_b0, prod_b1, prod_b2;
  logic signed [63:0]      prod_a1, prod_a2;
  logic signed [SUM_W-1:0] sum;

  assign prod_b0 = coef.b0 * sample;
  assign prod_b1 = coef.b1 * x1_r;
  assign prod_b2 = coef.b2 * x2_r;
  assign prod_a1 = coef.a1 * y1_r;
  assign prod_a2 = coef.a2 * y2_r;

  assign sum = $signed({prod_b0, 8'd0}) + $signed({prod_b1, 8'd0})
             + $signed({prod_b2, 8'd0}) - prod_a1 - prod_a2;

  assign sample_out = out_sample(sum);

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (update) begin
      x1_r <= sample;
      x2_r <= x1_r;
      y1_r <= state_value(sum);
      y2_r <= y1_r;
    end
  end

endmodule

// ===== design/stereo_biquad_filter_top.sv =====
// ----------------------------------------------------------------------------
// Stereo biquad filter, top level
// An accepted frame is held in the input register (in_data_r), then moves to the
// output register (out_data_r) and appears on out_data once the output side is
// free. Throughput: one frame per cycle while the output side does not stall;
// the feedback loop closes through the delay registers with no register in the path.
// Reset loads the pass-through coefficients (b0 = 1.0), clears the valid flags and the filter state.
// ----------------------------------------------------------------------------
module stereo_biquad_filter_top
  import sbq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  coef_t coef_r;
  in_t   in_data_r;
  out_t  out_data_r;
  logic  in_valid_r, out_valid_r;

  logic advance;
  logic identity;
  logic cfg_hit;
  logic signed [SAMPLE_W-1:0] left_y, right_y;
  out_t  result_nxt;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  assign identity = (coef_r.b0 == COEF_ONE) && (coef_r.b1 == '0) && (coef_r.b2 == '0)
                 && (coef_r.a1 == '0) && (coef_r.a2 == '0);

  assign cfg_hit = cfg_we && (cfg_index == REG_B0 || cfg_index == REG_B1 ||
                              cfg_index == REG_B2 || cfg_index == REG_A1 ||
                              cfg_index == REG_A2);

  sbq_channel u_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (cfg_hit),
    .update     (advance && !identity),
    .coef       (coef_r),
    .sample     (in_data_r.left_in),
    .sample_out (left_y)
  );

  sbq_channel u_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (cfg_hit),
    .update     (advance && !identity),
    .coef       (coef_r),
    .sample     (in_data_r.right_in),
    .sample_out (right_y)
  );

  always_comb begin
    result_nxt.left_out      = identity ? in_data_r.left_in  : left_y;
    result_nxt.right_out     = identity ? in_data_r.right_in : right_y;
    result_nxt.chunk_end_out = in_data_r.chunk_end_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= COEF_ONE;
      coef_r.b1 <= '0;
      coef_r.b2 <= '0;
      coef_r.a1 <= '0;
      coef_r.a2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:  coef_r.b0 <= cfg_data;
        REG_B1:  coef_r.b1 <= cfg_data;
        REG_B2:  coef_r.b2 <= cfg_data;
        REG_A1:  coef_r.a1 <= cfg_data;
        REG_A2:  coef_r.a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/sbq_checker.sv =====
// ----------------------------------------------------------------------------
// Stereo biquad filter checker
// Port-level checks on the handshake and pipeline timing of the top level.
// ----------------------------------------------------------------------------
module sbq_checker
  import sbq_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result transaction changed or dropped.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the output side was free.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_valid |=> out_valid)
    else $error("Accepted transaction did not reach the output in two cycles.");

endmodule

bind stereo_biquad_filter_top sbq_checker u_sbq_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Stereo biquad filter testbench
// Streams stereo frames through the filter under several coefficient sets,
// from pass-through and full-scale extremes to random filters. A scoreboard
// predicts each output frame from the accepted input and checks the results
// in order, while the source idles at random and the output side stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sbq_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 200;
  localparam int NUM_PHASES   = 12;
  localparam int HALF_PHASE   = 80;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_A2 + 3'd1;

  class biquad_scoreboard;
    logic signed [COEF_W-1:0]   coef[5];
    logic signed [SAMPLE_W-1:0] x_hist[2][2];
    logic signed [STATE_W-1:0]  y_hist[2][2];
    out_t                       expected_frames[$];
    int                         errors;

    function new();
      coef[REG_B0] = COEF_ONE;
      coef[REG_B1] = '0;
      coef[REG_B2] = '0;
      coef[REG_A1] = '0;
      coef[REG_A2] = '0;
      errors = 0;
      clear_history();
    endfunction

    function void clear_history();
      for (int ch = 0; ch < 2; ch++) begin
        for (int tap = 0; tap < 2; tap++) begin
          x_hist[ch][tap] = '0;
          y_hist[ch][tap] = '0;
        end
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      if (idx <= REG_A2) begin
        coef[idx] = val;
        clear_history();
      end
    endfunction

    function logic signed [SUM_W-1:0] trunc_to_zero(logic signed [SUM_W-1:0] v, int k);
      if (v < 0) begin
        return -((-v) >>> k);
      end
      return v >>> k;
    endfunction

    function logic signed [SAMPLE_W-1:0] filter_channel(int ch,
                                                        logic signed [SAMPLE_W-1:0] x);
      logic signed [SUM_W-1:0]    acc;
      logic signed [SUM_W-1:0]    q_out;
      logic signed [SUM_W-1:0]    q_state;
      logic signed [SAMPLE_W-1:0] y;
      logic signed [STATE_W-1:0]  y_state;
      acc = coef[REG_B0] * x * 256
          + coef[REG_B1] * x_hist[ch][0] * 256
          + coef[REG_B2] * x_hist[ch][1] * 256
          - coef[REG_A1] * y_hist[ch][0]
          - coef[REG_A2] * y_hist[ch][1];
      q_out = trunc_to_zero(acc, 36);
      if (q_out > 32767) begin
        y = 16'sh7FFF;
      end else if (q_out < -32768) begin
        y = 16'sh8000;
      end else begin
        y = q_out[SAMPLE_W-1:0];
      end
      q_state = trunc_to_zero(acc, 28);
      if (q_state > 64'sh7FFF_FFFF) begin
        y_state = 32'sh7FFF_FFFF;
      end else if (q_state < -64'sh8000_0000) begin
        y_state = 32'sh8000_0000;
      end else begin
        y_state = q_state[STATE_W-1:0];
      end
      x_hist[ch][1] = x_hist[ch][0];
      x_hist[ch][0] = x;
      y_hist[ch][1] = y_hist[ch][0];
      y_hist[ch][0] = y_state;
      return y;
    endfunction

    function void note_input(in_t frame);
      out_t predicted;
      if (coef[REG_B0] == COEF_ONE && coef[REG_B1] == 0 && coef[REG_B2] == 0 &&
          coef[REG_A1] == 0 && coef[REG_A2] == 0) begin
        predicted.left_out  = frame.left_in;
        predicted.right_out = frame.right_in;
      end else begin
        predicted.left_out  = filter_channel(0, frame.left_in);
        predicted.right_out = filter_channel(1, frame.right_in);
      end
      predicted.chunk_end_out = frame.chunk_end_in;
      expected_frames.push_back(predicted);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check(out_t got);
      out_t want;
      if (expected_frames.size() == 0) begin
        report($sformatf("unexpected transaction %h", got));
        return;
      end
      want = expected_frames.pop_front();
      if (got.left_out !== want.left_out) begin
        report($sformatf("left_out got %0d expected %0d", got.left_out, want.left_out));
      end
      if (got.right_out !== want.right_out) begin
        report($sformatf("right_out got %0d expected %0d", got.right_out, want.right_out));
      end
      if (got.chunk_end_out !== want.chunk_end_out) begin
        report($sformatf("chunk_end_out got %b expected %b",
                         got.chunk_end_out, want.chunk_end_out));
      end
    endtask

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  biquad_scoreboard sb;
  bit src_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  bit long_hold = 1'b0;
  int cycle_count = 0;

  stereo_biquad_filter_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_input(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check(out_data);
    end
  end

  initial begin
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  function automatic in_t make_frame(logic signed [SAMPLE_W-1:0] left,
                                     logic signed [SAMPLE_W-1:0] right, logic chunk_end);
    in_t frame;
    frame.left_in      = left;
    frame.right_in     = right;
    frame.chunk_end_in = chunk_end;
    return frame;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return $signed(16'($urandom_range(0, 511))) - 16'sd256;
      4: return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef_moderate();
    return 32'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
  endfunction

  task automatic send_frame(input in_t frame);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= frame;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_frame(make_frame(rand_sample(), rand_sample(), 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic send_directed();
    send_frame(make_frame(16'sh7FFF, 16'sh8000, 1'b1));
    send_frame(make_frame(16'sh8000, 16'sh7FFF, 1'b0));
    send_frame(make_frame(16'sh0000, 16'sh0000, 1'b1));
    send_frame(make_frame(-16'sd1, 16'sd1, 1'b0));
    send_frame(make_frame(16'sh5555, 16'shAAAA, 1'b1));
    send_frame(make_frame(16'shAAAA, 16'sh5555, 1'b0));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                           input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                           input logic [COEF_W-1:0] a2);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_directed();
    drain();
    set_coefs(32'hF000_0000, '0, '0, '0, '0);
    send_directed();
    drain();
    set_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_directed();
    drain();
    set_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_directed();
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 6)
        0: set_coefs(32'd18119000, 32'd36238000, 32'd18119000,
                     -32'sd306800000, 32'd110782000);
        1: set_coefs(COEF_ONE, '0, '0, rand_coef_moderate(), rand_coef_moderate());
        2: set_coefs(rand_coef_moderate(), rand_coef_moderate(), rand_coef_moderate(),
                     rand_coef_moderate(), rand_coef_moderate());
        3: set_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
        4: write_reg(REG_A1, rand_coef_moderate());
        default: begin
          if (p < 6) begin
            set_coefs(COEF_ONE, '0, '0, '0, '0);
          end else begin
            set_coefs('0, '0, '0, '0, '0);
          end
        end
      endcase
      src_idle_en = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      rx_idle_en  = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      if (p == 2 || p == 7) begin
        long_hold = 1'b1;
      end
      send_random(HALF_PHASE);
      drain();
      write_reg(REG_UNUSED_FIRST + 3'(p % 3), $urandom);
      send_random(HALF_PHASE);
      drain();
    end

    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected transactions never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sbq_pkg.sv
design/sbq_channel.sv
design/stereo_biquad_filter_top.sv
design/sbq_checker.sv
tb/tb_top.sv
